// File: design/imu_avg_pkg.sv
// Shared types and constants for the IMU decimating averager.
// Depends on nothing; every other design file refers to it by scoped names.
package imu_avg_pkg;

  localparam int WINDOW_TICKS = 5;
  localparam int AXES         = 6;
  localparam int SLOW_RATES   = 6;
  localparam int SAMPLE_W     = 16;
  localparam int FLAG_W       = SLOW_RATES + 1;
  localparam int PHASE_W      = 11;

  // Running sums need headroom for WINDOW_TICKS samples plus the sign.
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_TICKS) + 1;
  localparam int WIN_PH_W = $clog2(WINDOW_TICKS + 1);

  // Exact floor division of a SUM_W-bit magnitude by WINDOW_TICKS:
  // multiply by ceil(2^RECIP_SH / WINDOW_TICKS) and drop RECIP_SH bits.
  localparam int RECIP_SH = SUM_W + $clog2(WINDOW_TICKS);
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SH + WINDOW_TICKS - 1) / WINDOW_TICKS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [FLAG_W-1:0]          flags_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [WIN_PH_W-1:0]        win_ph_t;

  // Periods of the slow flags, bit1 upward.
  localparam phase_t SLOW_PERIOD [SLOW_RATES] = '{
    phase_t'(30), phase_t'(50), phase_t'(100),
    phase_t'(500), phase_t'(1000), phase_t'(2000)
  };

  // Per-request control carried from the accumulate stage to the output stage.
  typedef struct packed {
    logic   fresh;
    flags_t flags;
  } acc_ctl_t;

endpackage

// File: design/imu_avg_div.sv
// Signed division of one window sum by the window length, truncating toward zero.
// Depends on imu_avg_pkg for widths and the reciprocal constant.
module imu_avg_div (
  input  imu_avg_pkg::sum_t    sum,
  output imu_avg_pkg::sample_t avg
);

  logic                               neg;
  logic [imu_avg_pkg::SUM_W-1:0]      mag;
  logic [imu_avg_pkg::PROD_W-1:0]     prod;
  logic [imu_avg_pkg::SUM_W-1:0]      quo;
  logic [imu_avg_pkg::SAMPLE_W-1:0]   quo_lo;

  always_comb begin
    neg    = sum[imu_avg_pkg::SUM_W-1];
    // Divide the magnitude, then restore the sign: this truncates toward zero.
    mag    = neg ? imu_avg_pkg::SUM_W'(-sum) : imu_avg_pkg::SUM_W'(sum);
    prod   = imu_avg_pkg::PROD_W'(mag) * imu_avg_pkg::PROD_W'(imu_avg_pkg::RECIP);
    quo    = prod[imu_avg_pkg::RECIP_SH +: imu_avg_pkg::SUM_W];
    quo_lo = quo[imu_avg_pkg::SAMPLE_W-1:0];
    avg    = neg ? imu_avg_pkg::sample_t'(-quo_lo) : imu_avg_pkg::sample_t'(quo_lo);
  end

endmodule

// File: design/imu_avg_accum.sv
// Accumulate stage: running sums, window and rate phase counters, sticky flags.
// Depends on imu_avg_pkg; registers the closing sums and control for the output stage.
module imu_avg_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  imu_avg_pkg::sample_t   samples [imu_avg_pkg::AXES],
  input  imu_avg_pkg::flags_t    flag_clear,
  output imu_avg_pkg::sum_t      close_sums [imu_avg_pkg::AXES],
  output imu_avg_pkg::acc_ctl_t  ctl
);

  imu_avg_pkg::sum_t      sums_r       [imu_avg_pkg::AXES];
  imu_avg_pkg::sum_t      sums_nxt     [imu_avg_pkg::AXES];
  imu_avg_pkg::sum_t      close_sums_r [imu_avg_pkg::AXES];
  imu_avg_pkg::phase_t    rate_ph_r    [imu_avg_pkg::SLOW_RATES];
  imu_avg_pkg::phase_t    rate_ph_nxt  [imu_avg_pkg::SLOW_RATES];
  imu_avg_pkg::win_ph_t   win_ph_r;
  imu_avg_pkg::win_ph_t   win_ph_nxt;
  imu_avg_pkg::flags_t    flags_r;
  imu_avg_pkg::flags_t    flags_nxt;
  imu_avg_pkg::flags_t    set_mask;
  imu_avg_pkg::acc_ctl_t  ctl_r;
  logic                   win_close;

  always_comb begin
    for (int i = 0; i < imu_avg_pkg::AXES; i++) begin
      sums_nxt[i] = sums_r[i] + imu_avg_pkg::sum_t'(samples[i]);
    end

    win_close  = (win_ph_r == imu_avg_pkg::win_ph_t'(imu_avg_pkg::WINDOW_TICKS - 1));
    win_ph_nxt = win_close ? '0 : win_ph_r + imu_avg_pkg::win_ph_t'(1);

    set_mask    = '0;
    set_mask[0] = win_close;
    for (int i = 0; i < imu_avg_pkg::SLOW_RATES; i++) begin
      if (rate_ph_r[i] == imu_avg_pkg::SLOW_PERIOD[i] - imu_avg_pkg::phase_t'(1)) begin
        set_mask[i+1]  = 1'b1;
        rate_ph_nxt[i] = '0;
      end else begin
        rate_ph_nxt[i] = rate_ph_r[i] + imu_avg_pkg::phase_t'(1);
      end
    end

    // Clear first, then set: a flag firing on this tick survives its own ack.
    flags_nxt = (flags_r & ~flag_clear) | set_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < imu_avg_pkg::AXES; i++) begin
        sums_r[i] <= '0;
      end
      for (int i = 0; i < imu_avg_pkg::SLOW_RATES; i++) begin
        rate_ph_r[i] <= '0;
      end
      win_ph_r <= '0;
      flags_r  <= '0;
    end else if (take) begin
      for (int i = 0; i < imu_avg_pkg::AXES; i++) begin
        sums_r[i] <= win_close ? '0 : sums_nxt[i];
      end
      rate_ph_r <= rate_ph_nxt;
      win_ph_r  <= win_ph_nxt;
      flags_r   <= flags_nxt;
    end
  end

  // Hand the closing sums to the divider stage.
  always_ff @(posedge clk) begin
    if (take) begin
      close_sums_r <= sums_nxt;
      ctl_r.fresh  <= win_close;
      ctl_r.flags  <= flags_nxt;
    end
  end

  assign close_sums = close_sums_r;
  assign ctl        = ctl_r;

endmodule

// File: design/imu_decimating_averager_with_rate_flags_core.sv
// Usage notes for the IMU decimating averager with sticky rate flags.
// Input channel (in_valid / in_stall): one request per 1 ms tick carrying six
// signed IMU samples and a 7-bit flag acknowledge mask.
// Output channel (out_valid / out_stall): exactly one result per request, in
// order: the six held window averages, a fresh bit when the request closed a
// window of five ticks, and the sticky rate flags after the acknowledge.
// Path: a request accepted into the accumulate stage is registered there,
// then divided combinationally into the output register.
// Throughput: one request per cycle while out_stall is low; the accumulate
// and output registers are separate, so a request is taken while a result waits.
// When the receiver stalls, the result holds and at most one more request is
// still absorbed by the accumulate stage; after that in_stall rises.
// Reset (synchronous, rst_n low) clears sums, averages, phases and flags and
// empties both stages; no requests or results are in flight afterward.
// Depends on imu_avg_pkg, imu_avg_accum and imu_avg_div.
module imu_decimating_averager_with_rate_flags_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  imu_avg_pkg::sample_t in_accel_x,
  input  imu_avg_pkg::sample_t in_accel_y,
  input  imu_avg_pkg::sample_t in_accel_z,
  input  imu_avg_pkg::sample_t in_rate_x,
  input  imu_avg_pkg::sample_t in_rate_y,
  input  imu_avg_pkg::sample_t in_rate_z,
  input  imu_avg_pkg::flags_t  in_flag_clear,
  output logic                 out_valid,
  input  logic                 out_stall,
  output imu_avg_pkg::sample_t out_avg_accel_x,
  output imu_avg_pkg::sample_t out_avg_accel_y,
  output imu_avg_pkg::sample_t out_avg_accel_z,
  output imu_avg_pkg::sample_t out_avg_rate_x,
  output imu_avg_pkg::sample_t out_avg_rate_y,
  output imu_avg_pkg::sample_t out_avg_rate_z,
  output logic                 out_average_fresh,
  output imu_avg_pkg::flags_t  out_rate_flags
);

  imu_avg_pkg::sample_t  samples    [imu_avg_pkg::AXES];
  imu_avg_pkg::sum_t     close_sums [imu_avg_pkg::AXES];
  imu_avg_pkg::sample_t  quo        [imu_avg_pkg::AXES];
  imu_avg_pkg::sample_t  avg_r      [imu_avg_pkg::AXES];
  imu_avg_pkg::acc_ctl_t s1_ctl;
  imu_avg_pkg::flags_t   flags_r;
  logic                  fresh_r;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  logic                  s1_adv;
  logic                  take;

  assign samples[0] = in_accel_x;
  assign samples[1] = in_accel_y;
  assign samples[2] = in_accel_z;
  assign samples[3] = in_rate_x;
  assign samples[4] = in_rate_y;
  assign samples[5] = in_rate_z;

  // Advance the accumulate stage whenever the output register is free or draining.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign take     = in_valid && !in_stall;

  imu_avg_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .samples    (samples),
    .flag_clear (in_flag_clear),
    .close_sums (close_sums),
    .ctl        (s1_ctl)
  );

  for (genvar g = 0; g < imu_avg_pkg::AXES; g++) begin : g_div
    imu_avg_div u_div (
      .sum (close_sums[g]),
      .avg (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // The output averages double as the held averages, so they reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < imu_avg_pkg::AXES; i++) begin
        avg_r[i] <= '0;
      end
    end else if (s1_adv && s1_valid_r && s1_ctl.fresh) begin
      avg_r <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      fresh_r <= s1_ctl.fresh;
      flags_r <= s1_ctl.flags;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_avg_accel_x   = avg_r[0];
  assign out_avg_accel_y   = avg_r[1];
  assign out_avg_accel_z   = avg_r[2];
  assign out_avg_rate_x    = avg_r[3];
  assign out_avg_rate_y    = avg_r[4];
  assign out_avg_rate_z    = avg_r[5];
  assign out_average_fresh = fresh_r;
  assign out_rate_flags    = flags_r;

endmodule
